// ===== sv/crip_pkg.sv =====
// Shared types and constants of the cursor image rotate and pad block.
package crip_pkg;

    // Field widths of the request, response and configuration port
    localparam int OP_W         = 1;
    localparam int INDEX_W      = 12;
    localparam int PIXEL_W      = 32;
    localparam int COORD_W      = 8;
    localparam int CURSOR_DIM_W = 7;
    localparam int BUF_DIM_W    = 9;
    localparam int ORIENT_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;

    // Width of a source index: cursor term times cursor width plus offset
    localparam int SRC_IDX_W    = 2 * CURSOR_DIM_W;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMALLEST_BUFW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMALLEST_BUFH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_STRIDE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_ROWS      = 3'd6;

    // Reset values of the geometry registers
    localparam logic [CURSOR_DIM_W-1:0] CURSOR_DIM_RST = 7'd64;
    localparam logic [BUF_DIM_W-1:0]    BUF_DIM_RST    = 9'd64;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_NORMAL   = 2'd0,
        ORIENT_LEFT     = 2'd1,
        ORIENT_INVERTED = 2'd2,
        ORIENT_RIGHT    = 2'd3
    } t_orient;

endpackage

// ===== sv/crip_req_if.sv =====
// Request channel: image pixel loads and buffer pixel reads.
interface crip_req_if;
    logic                                valid;
    logic                                ready;
    logic [crip_pkg::OP_W-1:0]           op;
    logic [crip_pkg::INDEX_W-1:0]        pixel_index;
    logic [crip_pkg::PIXEL_W-1:0]        pixel_value;
    logic [crip_pkg::COORD_W-1:0]        out_row;
    logic [crip_pkg::COORD_W-1:0]        out_col;

    modport source (
        output valid, op, pixel_index, pixel_value, out_row, out_col,
        input  ready
    );
    modport sink (
        input  valid, op, pixel_index, pixel_value, out_row, out_col,
        output ready
    );
endinterface

// ===== sv/crip_rsp_if.sv =====
// Response channel: one buffer pixel per read request.
interface crip_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [crip_pkg::PIXEL_W-1:0]  pixel;
    logic                          outside_buffer;

    modport source (
        output valid, pixel, outside_buffer,
        input  ready
    );
    modport sink (
        input  valid, pixel, outside_buffer,
        output ready
    );
endinterface

// ===== sv/crip_image_ram.sv =====
// Cursor image memory: one write port, one read port with registered data.
module crip_image_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [crip_pkg::PIXEL_W-1:0]     i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [crip_pkg::PIXEL_W-1:0]     o_rdata
);

    logic [crip_pkg::PIXEL_W-1:0] r_mem [DEPTH];
    logic [crip_pkg::PIXEL_W-1:0] r_rdata;

    // Write the loaded pixel
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read and hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cursor_image_rotate_pad.sv =====
// Cursor image rotate and pad: top level.
//
// Holds a cursor image of 32-bit ARGB pixels and serves single pixels of the
// padded, rotated cursor buffer. Requests arrive on i_req: a load request
// (op 0) stores pixel_value at pixel_index and gives no response; a read
// request (op 1) gives one response on o_rsp with the pixel at out_row and
// out_col, 0 for padding, and outside_buffer set past the padded buffer.
// Geometry and orientation are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must do so only while no request is in flight; the block does not check.
// Throughput: one request per cycle while the receiver takes responses. Position
// checks and source terms are registered as a request is accepted, the address
// multiply and image memory read follow in stage 2, and the output register
// loads last. Loads and reads meet the memory in the same stage, so they see
// each other in order.
// Reset clears the pipeline and sets the registers to their defaults; the
// image memory is not cleared and holds nothing valid until loaded.
// When the receiver stalls, the response is held in the output register;
// empty stages still take new requests until the pipeline is full.
module cursor_image_rotate_pad #(
    parameter int MAX_IMAGE_PIXELS = 4096,
    parameter int MAX_BUFFER_DIM   = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [crip_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [crip_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    crip_req_if.sink                              i_req,
    crip_rsp_if.source                            o_rsp
);

    localparam int AW    = $clog2(MAX_IMAGE_PIXELS);
    localparam int CMP_W = ($clog2(MAX_IMAGE_PIXELS + 1) > crip_pkg::SRC_IDX_W + 1)
                         ? $clog2(MAX_IMAGE_PIXELS + 1) : crip_pkg::SRC_IDX_W + 1;
    localparam int SAT_W = ($clog2(MAX_BUFFER_DIM + 1) > crip_pkg::BUF_DIM_W)
                         ? $clog2(MAX_BUFFER_DIM + 1) : crip_pkg::BUF_DIM_W;
    localparam int CDW   = crip_pkg::CURSOR_DIM_W;
    localparam int BDW   = crip_pkg::BUF_DIM_W;

    // Clip a buffer dimension to the largest supported value
    function automatic logic [BDW-1:0] sat_dim(input logic [BDW-1:0] v);
        logic [BDW-1:0] res;
        res = v;
        if (SAT_W'(v) > SAT_W'(MAX_BUFFER_DIM)) begin
            res = BDW'(MAX_BUFFER_DIM);
        end
        return res;
    endfunction

    // Configuration registers
    crip_pkg::t_orient r_orient;
    logic [CDW-1:0]    r_cw;
    logic [CDW-1:0]    r_ch;
    logic [BDW-1:0]    r_sbw;
    logic [BDW-1:0]    r_sbh;
    logic [BDW-1:0]    r_stride;
    logic [BDW-1:0]    r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= crip_pkg::ORIENT_NORMAL;
            r_cw     <= crip_pkg::CURSOR_DIM_RST;
            r_ch     <= crip_pkg::CURSOR_DIM_RST;
            r_sbw    <= sat_dim(crip_pkg::BUF_DIM_RST);
            r_sbh    <= sat_dim(crip_pkg::BUF_DIM_RST);
            r_stride <= sat_dim(crip_pkg::BUF_DIM_RST);
            r_rows   <= sat_dim(crip_pkg::BUF_DIM_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crip_pkg::REG_ORIENTATION: begin
                    r_orient <= crip_pkg::t_orient'(i_cfg_data[crip_pkg::ORIENT_W-1:0]);
                end
                crip_pkg::REG_CURSOR_WIDTH:  r_cw     <= i_cfg_data[CDW-1:0];
                crip_pkg::REG_CURSOR_HEIGHT: r_ch     <= i_cfg_data[CDW-1:0];
                crip_pkg::REG_SMALLEST_BUFW: r_sbw    <= sat_dim(i_cfg_data);
                crip_pkg::REG_SMALLEST_BUFH: r_sbh    <= sat_dim(i_cfg_data);
                crip_pkg::REG_BUF_STRIDE:    r_stride <= sat_dim(i_cfg_data);
                crip_pkg::REG_BUF_ROWS:      r_rows   <= sat_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Geometry of content and padded buffer
    logic           sideways;
    logic [BDW-1:0] lim_w;
    logic [BDW-1:0] lim_h;
    logic [CDW-1:0] iw;
    logic [CDW-1:0] ih;
    logic [BDW-1:0] bcols;
    logic [BDW-1:0] brows;

    always_comb begin
        sideways = (r_orient == crip_pkg::ORIENT_LEFT) || (r_orient == crip_pkg::ORIENT_RIGHT);
        lim_w    = sideways ? r_sbw : r_sbh;
        lim_h    = sideways ? r_sbh : r_sbw;
        iw       = (lim_w < BDW'(r_cw)) ? lim_w[CDW-1:0] : r_cw;
        ih       = (lim_h < BDW'(r_ch)) ? lim_h[CDW-1:0] : r_ch;
        bcols    = (lim_w > r_stride) ? lim_w : r_stride;
        brows    = (lim_h > r_rows) ? lim_h : r_rows;
    end

    // Pipeline control
    logic                      r_s1_v;
    logic [crip_pkg::OP_W-1:0] r_s1_op;
    logic                      r_s2_v;
    logic                      r_out_v;
    logic                      out_adv;
    logic                      s2_adv;
    logic                      s1_free;
    logic                      accept;
    logic                      s1_load;
    logic                      s1_read;

    assign out_adv = !r_out_v || o_rsp.ready;
    assign s2_adv  = !r_s2_v || out_adv;
    assign s1_load = r_s1_v && (r_s1_op == crip_pkg::OP_LOAD);
    assign s1_read = r_s1_v && (r_s1_op == crip_pkg::OP_READ);
    assign s1_free = !r_s1_v || s1_load || s2_adv;
    assign accept  = i_req.valid && s1_free;
    assign i_req.ready = s1_free;

    // Stage 1 inputs: position checks and source index terms
    logic [crip_pkg::COORD_W-1:0] row;
    logic [crip_pkg::COORD_W-1:0] col;
    logic                         outside;
    logic                         in_content;
    logic [CDW-1:0]               mul_term;
    logic [CDW-1:0]               add_term;
    logic                         load_ok;

    always_comb begin
        row        = i_req.out_row;
        col        = i_req.out_col;
        outside    = (BDW'(row) >= brows) || (BDW'(col) >= bcols);
        in_content = 1'b0;
        mul_term   = row[CDW-1:0];
        add_term   = col[CDW-1:0];
        unique case (r_orient)
            crip_pkg::ORIENT_NORMAL: begin
                in_content = (row < 8'(ih)) && (col < 8'(iw));
                mul_term   = row[CDW-1:0];
                add_term   = col[CDW-1:0];
            end
            crip_pkg::ORIENT_INVERTED: begin
                in_content = (row < 8'(ih)) && (col < 8'(iw));
                mul_term   = ih - 7'd1 - row[CDW-1:0];
                add_term   = iw - 7'd1 - col[CDW-1:0];
            end
            crip_pkg::ORIENT_LEFT: begin
                in_content = (row < 8'(iw)) && (col < 8'(ih));
                mul_term   = col[CDW-1:0];
                add_term   = iw - 7'd1 - row[CDW-1:0];
            end
            crip_pkg::ORIENT_RIGHT: begin
                in_content = (row < 8'(iw)) && (col < 8'(ih));
                mul_term   = ih - 7'd1 - col[CDW-1:0];
                add_term   = row[CDW-1:0];
            end
        endcase
        load_ok = CMP_W'(i_req.pixel_index) < CMP_W'(MAX_IMAGE_PIXELS);
    end

    // Stage 1 registers
    logic [AW-1:0]                r_s1_widx;
    logic                         r_s1_wok;
    logic [crip_pkg::PIXEL_W-1:0] r_s1_wdata;
    logic                         r_s1_fetch;
    logic                         r_s1_out;
    logic [CDW-1:0]               r_s1_mul;
    logic [CDW-1:0]               r_s1_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= i_req.op;
            r_s1_widx  <= AW'(i_req.pixel_index);
            r_s1_wok   <= load_ok;
            r_s1_wdata <= i_req.pixel_value;
            r_s1_fetch <= in_content && !outside;
            r_s1_out   <= outside;
            r_s1_mul   <= mul_term;
            r_s1_add   <= add_term;
        end
    end

    // Stage 2: source address, memory read or write
    logic [crip_pkg::SRC_IDX_W-1:0] src_idx;
    logic                           src_ok;
    logic                           mem_re;
    logic                           mem_we;
    logic [crip_pkg::PIXEL_W-1:0]   mem_rdata;

    always_comb begin
        src_idx = crip_pkg::SRC_IDX_W'(r_s1_mul) * crip_pkg::SRC_IDX_W'(r_cw)
                + crip_pkg::SRC_IDX_W'(r_s1_add);
        src_ok  = r_s1_fetch && (CMP_W'(src_idx) < CMP_W'(MAX_IMAGE_PIXELS));
        mem_re  = s1_read && s2_adv && src_ok;
        mem_we  = s1_load && r_s1_wok;
    end

    crip_image_ram #(
        .DEPTH (MAX_IMAGE_PIXELS)
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s1_widx),
        .i_wdata (r_s1_wdata),
        .i_re    (mem_re),
        .i_raddr (AW'(src_idx)),
        .o_rdata (mem_rdata)
    );

    logic r_s2_zero;
    logic r_s2_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_adv) begin
            r_s2_v <= s1_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && s1_read) begin
            r_s2_zero <= !src_ok;
            r_s2_out  <= r_s1_out;
        end
    end

    // Output register: hold the response until it is taken
    logic [crip_pkg::PIXEL_W-1:0] r_out_pixel;
    logic                         r_out_outside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_adv) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s2_v) begin
            r_out_pixel   <= r_s2_zero ? '0 : mem_rdata;
            r_out_outside <= r_s2_out;
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.pixel          = r_out_pixel;
    assign o_rsp.outside_buffer = r_out_outside;

endmodule
